// ===== hdl/point_to_segment_nearest_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest point on segment block
// Shared concurrent check forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_SEGMENT_NEAREST_DEFINES_SVH
`define POINT_TO_SEGMENT_NEAREST_DEFINES_SVH

// same-cycle implication
`define PTSN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication after a fixed number of cycles
`define PTSN_ASSERT_DELAY(label, ante, n, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// ===== hdl/ptsn_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsn_pkg
// Widths, codes and payload types of the nearest point on segment block.
// ----------------------------------------------------------------------------
package ptsn_pkg;

   localparam int CW   = 32;          // coordinate width
   localparam int DW   = CW + 1;      // coordinate difference
   localparam int PW   = 2 * DW;      // signed difference product
   localparam int NW   = 2 * CW + 3;  // signed dot(D,V)
   localparam int DENW = 2 * CW + 2;  // unsigned dot(D,D)
   localparam int NMW  = 2 * CW + 2;  // magnitude of dot(D,V)
   localparam int HW   = NMW / 2;     // half the width of that magnitude
   localparam int MW   = NMW + CW;    // |dot(D,V)| * |D_i|
   localparam int QB   = CW + 2;      // quotient bits kept before overflow
   localparam int QSW  = QB + 1;      // signed quotient
   localparam int EW   = QSW + 1;     // nearest point and offset before clipping
   localparam int RTW  = CW + 1;      // root width
   localparam int RW   = 2 * RTW;     // radicand width
   localparam int SW   = RW + 2;      // sum of three squares
   localparam int EPSW = 16;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON      = 1'b1;

   localparam logic [1:0] WHERE_INTERIOR = 2'd0;
   localparam logic [1:0] WHERE_P1       = 2'd1;
   localparam logic [1:0] WHERE_P2       = 2'd2;
   localparam logic [1:0] WHERE_DEGEN    = 2'd3;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p1_z;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p2_z;
   } ptsn_req_type;

   typedef struct packed {
      coord_type       near_x;
      coord_type       near_y;
      coord_type       near_z;
      logic [CW:0]     distance;
      logic [1:0]      where_found;
      logic            saturated;
   } ptsn_rsp_type;

endpackage

// ===== hdl/ptsn_div.sv =====
// ----------------------------------------------------------------------------
// ptsn_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module ptsn_div
   import ptsn_pkg::*;
(
   input  logic            clock,
   input  logic [MW-1:0]   mag,
   input  logic [DENW-1:0] den,
   output logic [QB-1:0]   quo,
   output logic            ovf
);

   logic [DENW-1:0] rem_ff [QB+1];
   logic [DENW-1:0] rem_in [QB+1];
   logic [DENW-1:0] den_ff [QB+1];
   logic [DENW-1:0] den_in [QB+1];
   logic [QB-1:0]   low_ff [QB+1];
   logic [QB-1:0]   low_in [QB+1];
   logic [QB-1:0]   quo_ff [QB+1];
   logic [QB-1:0]   quo_in [QB+1];
   logic [QB:0]     ovf_ff;
   logic [QB:0]     ovf_in;
   logic [DENW:0]   trial  [QB+1];
   logic [DENW:0]   diff   [QB+1];
   logic [QB:0]     ge;

   always_comb begin
      for (int k = 0; k <= QB; k++) begin
         if (k == 0) begin
            // quotient would need more than QB bits when the top part reaches den
            trial[k]  = '0;
            diff[k]   = '0;
            ge[k]     = 1'b0;
            rem_in[k] = DENW'(mag[MW-1:QB]);
            ovf_in[k] = DENW'(mag[MW-1:QB]) >= den;
            low_in[k] = mag[QB-1:0];
            quo_in[k] = '0;
            den_in[k] = den;
         end else begin
            trial[k]  = {rem_ff[k-1], low_ff[k-1][QB-1]};
            diff[k]   = trial[k] - {1'b0, den_ff[k-1]};
            ge[k]     = ~diff[k][DENW];
            rem_in[k] = ge[k] ? diff[k][DENW-1:0] : trial[k][DENW-1:0];
            ovf_in[k] = ovf_ff[k-1];
            low_in[k] = low_ff[k-1] << 1;
            quo_in[k] = {quo_ff[k-1][QB-2:0], ge[k]};
            den_in[k] = den_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QB; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         low_ff[k] <= low_in[k];
         quo_ff[k] <= quo_in[k];
         ovf_ff[k] <= ovf_in[k];
      end
   end

   assign quo = quo_ff[QB];
   assign ovf = ovf_ff[QB];

endmodule

// ===== hdl/point_to_segment_nearest.sv =====
// ----------------------------------------------------------------------------
// point_to_segment_nearest
// Nearest point on a 3-D line or segment to a query point, with distance.
// ----------------------------------------------------------------------------
//
//   channel  ports                          direction  handshake
//   request  start, busy, req_data          in         start & !busy
//   response rsp_valid, rsp_data            out        one-cycle strobe
//   csr      csr_wr_en, csr_index, csr_wdata in        write on csr_wr_en
//
// Fully pipelined: one item may enter every cycle; busy is always low.
// Most of the pipeline from accept to the rsp_valid strobe is the divider
// (one quotient bit per stage) and the square root (one root bit per stage).
// Synchronous reset clears all valid bits and sets segment_mode and epsilon
// to 1. No stall exists: the receiver takes every strobe.
//
`include "point_to_segment_nearest_defines.svh"
module point_to_segment_nearest
   import ptsn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ptsn_req_type         req_data,
   output logic                 rsp_valid,
   output ptsn_rsp_type         rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [EPSW-1:0]      csr_wdata
);

   localparam int RMW     = RTW + 2;
   localparam int LATENCY = 6 + (QB + 1) + 3 + 1 + RTW + 1;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW:0] DIST_MAX = {(CW+1){1'b1}};

   // context that rides alongside the arithmetic
   typedef struct packed {
      logic                 valid;
      logic                 degen;
      logic [1:0]           where;
      logic [2:0]           neg;
      logic [2:0][CW-1:0]   a;
      logic [2:0][DW-1:0]   d;
      logic [2:0][DW-1:0]   v;
   } pipe_type;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           where;
      logic                 sat;
      logic                 dist_ovf;
      logic [2:0][CW-1:0]   near;
   } tail_type;

   function automatic logic [DW-1:0] abs_d(input logic [DW-1:0] x);
      return x[DW-1] ? (~x + 1'b1) : x;
   endfunction

   // ---------------------------------------------------------------- config
   logic             seg_mode_ff;
   logic [EPSW-1:0]  eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_mode_ff <= 1'b1;
         eps_ff      <= EPSW'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEGMENT_MODE: seg_mode_ff <= csr_wdata[0];
            CSR_EPSILON:      eps_ff      <= csr_wdata;
            default:          ;
         endcase
      end
   end

   assign busy = 1'b0;

   // ------------------------------------------- stage 1: D = P2-P1, V = P-P1
   coord_type pt_c [3];
   coord_type a_c  [3];
   coord_type b_c  [3];
   pipe_type  s1_in, s1_ff;

   always_comb begin
      pt_c[0] = req_data.point_x;
      pt_c[1] = req_data.point_y;
      pt_c[2] = req_data.point_z;
      a_c[0]  = req_data.p1_x;
      a_c[1]  = req_data.p1_y;
      a_c[2]  = req_data.p1_z;
      b_c[0]  = req_data.p2_x;
      b_c[1]  = req_data.p2_y;
      b_c[2]  = req_data.p2_z;
      s1_in       = '0;
      s1_in.valid = start;
      s1_in.where = WHERE_INTERIOR;
      for (int i = 0; i < 3; i++) begin
         s1_in.a[i] = a_c[i];
         s1_in.d[i] = DW'(b_c[i]) - DW'(a_c[i]);
         s1_in.v[i] = DW'(pt_c[i]) - DW'(a_c[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_ff <= '0;
      else       s1_ff <= s1_in;
   end

   // ------------------------------- stage 2: per-axis products, coincidence
   logic signed [PW-1:0] dv_s2_ff [3];
   logic signed [PW-1:0] dd_s2_ff [3];
   logic [2:0]           close_d;
   pipe_type             s2_in, s2_ff;

   always_comb begin
      s2_in = s1_ff;
      for (int i = 0; i < 3; i++) begin
         close_d[i] = abs_d(s1_ff.d[i]) <= DW'(eps_ff);
      end
      s2_in.degen = &close_d;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dv_s2_ff[i] <= $signed(s1_ff.d[i]) * $signed(s1_ff.v[i]);
         dd_s2_ff[i] <= $signed(s1_ff.d[i]) * $signed(s1_ff.d[i]);
      end
      if (reset) s2_ff <= '0;
      else       s2_ff <= s2_in;
   end

   // ---------------------------------------------- stage 3: dot products
   logic signed [NW-1:0] num_s3_ff;
   logic [DENW-1:0]      den_s3_ff;
   pipe_type             s3_ff;

   always_ff @(posedge clock) begin
      num_s3_ff <= NW'(dv_s2_ff[0]) + NW'(dv_s2_ff[1]) + NW'(dv_s2_ff[2]);
      den_s3_ff <= DENW'(dd_s2_ff[0]) + DENW'(dd_s2_ff[1]) + DENW'(dd_s2_ff[2]);
      if (reset) s3_ff <= '0;
      else       s3_ff <= s2_ff;
   end

   // ------------------------------- stage 4: classify, take magnitudes
   logic            num_neg;
   logic [NW-1:0]   num_abs;
   pipe_type        s4_in, s4_ff;
   logic [NMW-1:0]  nmag_s4_ff;
   logic [CW-1:0]   dmag_s4_ff [3];
   logic [DENW-1:0] den_s4_ff;

   always_comb begin
      s4_in   = s3_ff;
      num_neg = num_s3_ff[NW-1];
      num_abs = num_neg ? (~num_s3_ff + 1'b1) : num_s3_ff;
      // beyond P2 is tested before before-P1
      if (s3_ff.degen) begin
         s4_in.where = WHERE_DEGEN;
      end else if (seg_mode_ff && (num_s3_ff >= $signed({1'b0, den_s3_ff}))) begin
         s4_in.where = WHERE_P2;
      end else if (seg_mode_ff && (num_neg || (num_s3_ff == '0))) begin
         s4_in.where = WHERE_P1;
      end else begin
         s4_in.where = WHERE_INTERIOR;
      end
      for (int i = 0; i < 3; i++) begin
         s4_in.neg[i] = num_neg ^ s3_ff.d[i][DW-1];
      end
   end

   always_ff @(posedge clock) begin
      nmag_s4_ff <= num_abs[NMW-1:0];
      den_s4_ff  <= den_s3_ff;
      for (int i = 0; i < 3; i++) begin
         // |D_i| never exceeds 2^CW - 1
         dmag_s4_ff[i] <= CW'(abs_d(s3_ff.d[i]));
      end
      if (reset) s4_ff <= '0;
      else       s4_ff <= s4_in;
   end

   // ----------------------- stage 5: |num| * |D_i| as two partial products
   logic [HW+CW-1:0] pp_lo_s5_ff [3];
   logic [HW+CW-1:0] pp_hi_s5_ff [3];
   logic [DENW-1:0]  den_s5_ff;
   pipe_type         s5_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pp_lo_s5_ff[i] <= nmag_s4_ff[HW-1:0] * dmag_s4_ff[i];
         pp_hi_s5_ff[i] <= nmag_s4_ff[NMW-1:HW] * dmag_s4_ff[i];
      end
      den_s5_ff <= den_s4_ff;
      if (reset) s5_ff <= '0;
      else       s5_ff <= s4_ff;
   end

   // ------------------------------------ stage 6: combine partial products
   logic [MW-1:0]   mag_s6_ff [3];
   logic [DENW-1:0] den_s6_ff;
   pipe_type        s6_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag_s6_ff[i] <= MW'(pp_lo_s5_ff[i]) + (MW'(pp_hi_s5_ff[i]) << HW);
      end
      den_s6_ff <= den_s5_ff;
      if (reset) s6_ff <= '0;
      else       s6_ff <= s5_ff;
   end

   // ------------------------- dividers, one per axis, with a matching delay
   logic [QB-1:0] quo [3];
   logic [2:0]    ovf;
   pipe_type      side_ff [QB+1];

   for (genvar g = 0; g < 3; g++) begin : g_div
      ptsn_div u_div (
         .clock (clock),
         .mag   (mag_s6_ff[g]),
         .den   (den_s6_ff),
         .quo   (quo[g]),
         .ovf   (ovf[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) side_ff[k] <= '0;
      end else begin
         side_ff[0] <= s6_ff;
         for (int k = 1; k <= QB; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // --------------------- stage Q: pick offset from P1, form N and P - N
   pipe_type             pq;
   logic signed [QSW-1:0] qs  [3];
   logic signed [QSW-1:0] sel [3];
   logic signed [EW-1:0]  near_q_in [3];
   logic signed [EW-1:0]  e_q_in    [3];
   logic [2:0]            ovf_q_in;
   logic signed [EW-1:0]  near_q_ff [3];
   logic signed [EW-1:0]  e_q_ff    [3];
   logic [2:0]            ovf_q_ff;
   pipe_type              q_ff;

   always_comb begin
      pq = side_ff[QB];
      for (int i = 0; i < 3; i++) begin
         qs[i] = {1'b0, quo[i]};
         if (pq.neg[i]) qs[i] = -qs[i];
         case (pq.where)
            WHERE_P2:       sel[i] = QSW'($signed(pq.d[i]));
            WHERE_INTERIOR: sel[i] = qs[i];
            default:        sel[i] = '0;
         endcase
         near_q_in[i] = EW'($signed(pq.a[i])) + EW'(sel[i]);
         e_q_in[i]    = EW'($signed(pq.v[i])) - EW'(sel[i]);
         ovf_q_in[i]  = ovf[i] && (pq.where == WHERE_INTERIOR);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         near_q_ff[i] <= near_q_in[i];
         e_q_ff[i]    <= e_q_in[i];
      end
      ovf_q_ff <= ovf_q_in;
      if (reset) q_ff <= '0;
      else       q_ff <= pq;
   end

   // ------------------------ stage C: clip N, offset magnitudes, overflow
   logic [EW-1:0]  ea [3];
   logic [2:0]     big;
   logic [2:0]     sat_c;
   tail_type       c_in, c_ff;
   logic [RTW-1:0] em_c_ff [3];

   always_comb begin
      c_in       = '0;
      c_in.valid = q_ff.valid;
      c_in.where = q_ff.where;
      for (int i = 0; i < 3; i++) begin
         // a quotient that overflowed puts N far outside in the sign's direction
         if (ovf_q_ff[i]) begin
            c_in.near[i] = q_ff.neg[i] ? CMIN : CMAX;
            sat_c[i]     = 1'b1;
         end else if (near_q_ff[i] > EW'(CMAX)) begin
            c_in.near[i] = CMAX;
            sat_c[i]     = 1'b1;
         end else if (near_q_ff[i] < EW'(CMIN)) begin
            c_in.near[i] = CMIN;
            sat_c[i]     = 1'b1;
         end else begin
            c_in.near[i] = near_q_ff[i][CW-1:0];
            sat_c[i]     = 1'b0;
         end
         ea[i]  = e_q_ff[i][EW-1] ? (~e_q_ff[i] + 1'b1) : e_q_ff[i];
         big[i] = |ea[i][EW-1:RTW];
      end
      c_in.sat      = |sat_c;
      c_in.dist_ovf = (|ovf_q_ff) || (|big);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) em_c_ff[i] <= ea[i][RTW-1:0];
      if (reset) c_ff <= '0;
      else       c_ff <= c_in;
   end

   // --------------------------------------------------- stage M: squares
   logic [RW-1:0] sq_m_ff [3];
   tail_type      m_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) sq_m_ff[i] <= em_c_ff[i] * em_c_ff[i];
      if (reset) m_ff <= '0;
      else       m_ff <= c_ff;
   end

   // ------------- stage A (root stage 0): sum, then one root bit per stage
   logic [SW-1:0]   sum_a;
   logic [RMW-1:0]  rt_rem_ff  [RTW+1];
   logic [RMW-1:0]  rt_rem_in  [RTW+1];
   logic [RTW-1:0]  rt_root_ff [RTW+1];
   logic [RTW-1:0]  rt_root_in [RTW+1];
   logic [RW-1:0]   rt_rad_ff  [RTW+1];
   logic [RW-1:0]   rt_rad_in  [RTW+1];
   tail_type        rt_tail_ff [RTW+1];
   tail_type        rt_tail_in [RTW+1];
   logic [RMW+1:0]  rt_r       [RTW+1];
   logic [RMW+1:0]  rt_trial   [RTW+1];
   logic [RMW+1:0]  rt_diff    [RTW+1];
   logic [RTW:0]    rt_ge;

   always_comb begin
      sum_a = SW'(sq_m_ff[0]) + SW'(sq_m_ff[1]) + SW'(sq_m_ff[2]);
      for (int j = 0; j <= RTW; j++) begin
         if (j == 0) begin
            rt_r[j]       = '0;
            rt_trial[j]   = '0;
            rt_diff[j]    = '0;
            rt_ge[j]      = 1'b0;
            rt_rem_in[j]  = '0;
            rt_root_in[j] = '0;
            rt_rad_in[j]  = sum_a[RW-1:0];
            rt_tail_in[j] = m_ff;
            rt_tail_in[j].dist_ovf = m_ff.dist_ovf || (|sum_a[SW-1:RW]);
         end else begin
            // bring down two radicand bits, try root*4+1
            rt_r[j]       = {rt_rem_ff[j-1], rt_rad_ff[j-1][RW-1:RW-2]};
            rt_trial[j]   = (RMW+2)'({rt_root_ff[j-1], 2'b01});
            rt_diff[j]    = rt_r[j] - rt_trial[j];
            rt_ge[j]      = rt_r[j] >= rt_trial[j];
            rt_rem_in[j]  = rt_ge[j] ? rt_diff[j][RMW-1:0] : rt_r[j][RMW-1:0];
            rt_root_in[j] = {rt_root_ff[j-1][RTW-2:0], rt_ge[j]};
            rt_rad_in[j]  = rt_rad_ff[j-1] << 2;
            rt_tail_in[j] = rt_tail_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= RTW; j++) begin
         rt_rem_ff[j]  <= rt_rem_in[j];
         rt_root_ff[j] <= rt_root_in[j];
         rt_rad_ff[j]  <= rt_rad_in[j];
         if (reset) rt_tail_ff[j] <= '0;
         else       rt_tail_ff[j] <= rt_tail_in[j];
      end
   end

   // ------------------------------------------------------ output register
   logic         rsp_valid_ff;
   ptsn_rsp_type rsp_data_ff;
   tail_type     fin;

   assign fin = rt_tail_ff[RTW];

   always_ff @(posedge clock) begin
      rsp_data_ff.near_x      <= fin.near[0];
      rsp_data_ff.near_y      <= fin.near[1];
      rsp_data_ff.near_z      <= fin.near[2];
      rsp_data_ff.distance    <= fin.dist_ovf ? DIST_MAX : rt_root_ff[RTW];
      rsp_data_ff.where_found <= fin.where;
      rsp_data_ff.saturated   <= fin.sat;
      rsp_valid_ff            <= reset ? 1'b0 : fin.valid;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------ checks
   `PTSN_ASSERT_DELAY(a_fixed_latency, start && !busy, LATENCY, rsp_valid,
      "accepted item did not come out after the pipeline latency")
   `PTSN_ASSERT_IMP(a_clamp_no_sat, rsp_valid && (rsp_data.where_found != WHERE_INTERIOR),
      !rsp_data.saturated, "clamped or degenerate item flagged saturated")
   `PTSN_ASSERT_IMP(a_clamp_dist, rsp_valid && (rsp_data.where_found != WHERE_INTERIOR),
      rsp_data.distance != DIST_MAX, "clamped or degenerate item hit distance limit")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for point_to_segment_nearest. A directed table covers
// the degenerate, clamped, interior and saturating cases and the coordinate
// extremes. Random phases follow, each under its own segment_mode/epsilon
// setting and sender idle rate. Items without an answer in the table are
// predicted with exact wide arithmetic, and each strobed result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import ptsn_pkg::*;

   localparam int ONE        = 32'h0001_0000;   // 1.0 in Q16.16
   localparam int STALL_MAX  = 5000;            // cycles with no traffic
   localparam int DRAIN_WAIT = 300;             // covers the pipeline depth
   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 150;

   typedef logic signed [255:0] big_type;

   typedef struct {
      ptsn_req_type req;
      logic         seg;
      logic [15:0]  eps;
      bit           typed;     // expected result given in the row
      ptsn_rsp_type rsp;
   } vector_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   ptsn_req_type         req_data = '0;
   logic                 rsp_valid;
   ptsn_rsp_type         rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SEGMENT_MODE;
   logic [EPSW-1:0]      csr_wdata = '0;

   // shadow of the block's registers
   logic        seg_mode = 1'b1;
   logic [15:0] eps_val  = 16'd1;

   ptsn_rsp_type pending_nearest[$];
   int           fail_count = 0;
   int           items_sent = 0;
   int           results_seen = 0;
   int           quiet_cycles = 0;

   always #6 clock = ~clock;

   point_to_segment_nearest u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Exact nearest point: project onto P1->P2, clamp in segment mode, then
   // measure to the unclipped point and clip the coordinates afterwards.
   function automatic ptsn_rsp_type predict_nearest(ptsn_req_type r, logic seg,
                                                    logic [15:0] eps);
      big_type     pt[3], a[3], b[3], d[3], nr[3];
      big_type     num, den, off, sq, lo, hi, dmax;
      logic [255:0] c;
      logic [63:0] root, cand;
      bit          degen;
      logic [1:0]  wh;
      ptsn_rsp_type o;
      pt[0] = r.point_x; pt[1] = r.point_y; pt[2] = r.point_z;
      a[0] = r.p1_x;     a[1] = r.p1_y;     a[2] = r.p1_z;
      b[0] = r.p2_x;     b[1] = r.p2_y;     b[2] = r.p2_z;
      num = 0;
      den = 0;
      degen = 1'b1;
      for (int i = 0; i < 3; i++) begin
         d[i] = b[i] - a[i];
         if ((d[i] < 0 ? -d[i] : d[i]) > big_type'(eps)) degen = 1'b0;
         num += d[i] * (pt[i] - a[i]);
         den += d[i] * d[i];
      end
      if (degen) begin
         wh = WHERE_DEGEN;
         nr = a;
      end else if (seg && num >= den) begin
         wh = WHERE_P2;
         nr = b;
      end else if (seg && num <= 0) begin
         wh = WHERE_P1;
         nr = a;
      end else begin
         wh = WHERE_INTERIOR;
         // signed division truncates toward zero
         for (int i = 0; i < 3; i++) nr[i] = a[i] + (num * d[i]) / den;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         off = pt[i] - nr[i];
         sq += off * off;
      end
      root = '0;
      for (int k = 63; k >= 0; k--) begin
         cand = root | (64'd1 << k);
         c = {192'd0, cand} * {192'd0, cand};
         if (c <= sq) root = cand;
      end
      dmax = (big_type'(1) <<< 33) - 1;
      if (big_type'({192'd0, root}) > dmax) root = dmax[63:0];
      lo = -(big_type'(1) <<< 31);
      hi = (big_type'(1) <<< 31) - 1;
      o.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (nr[i] < lo) begin
            nr[i] = lo;
            o.saturated = 1'b1;
         end else if (nr[i] > hi) begin
            nr[i] = hi;
            o.saturated = 1'b1;
         end
      end
      o.near_x      = nr[0][31:0];
      o.near_y      = nr[1][31:0];
      o.near_z      = nr[2][31:0];
      o.distance    = root[32:0];
      o.where_found = wh;
      return o;
   endfunction

   function automatic ptsn_req_type make_query(int px, int py, int pz, int ax, int ay,
                                               int az, int bx, int by, int bz);
      ptsn_req_type r;
      r = '{px, py, pz, ax, ay, az, bx, by, bz};
      return r;
   endfunction

   function automatic ptsn_rsp_type make_answer(int nx, int ny, int nz, longint dist_len,
                                                logic [1:0] wh);
      ptsn_rsp_type o;
      o.near_x = nx; o.near_y = ny; o.near_z = nz;
      o.distance = dist_len[32:0];
      o.where_found = wh;
      o.saturated = 1'b0;
      return o;
   endfunction

   function automatic int small_coord();
      return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
   endfunction

   // Random query: wide-open noise, small well-conditioned geometry, lines
   // right at the epsilon boundary, and corner coordinates.
   function automatic ptsn_req_type random_query(logic [15:0] eps);
      ptsn_req_type r;
      int spread;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      end else if (kind < 7) begin
         r = make_query(small_coord(), small_coord(), small_coord(), small_coord(),
                        small_coord(), small_coord(), small_coord(), small_coord(),
                        small_coord());
      end else if (kind < 9) begin
         // hover around the degenerate threshold
         spread = int'(eps) + 2;
         r = make_query(small_coord(), small_coord(), small_coord(), small_coord(),
                        small_coord(), small_coord(), 0, 0, 0);
         r.p2_x = r.p1_x + $urandom_range(0, 2 * spread) - spread;
         r.p2_y = r.p1_y + $urandom_range(0, 2 * spread) - spread;
         r.p2_z = r.p1_z + $urandom_range(0, 2 * spread) - spread;
      end else begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
         r.p1_x = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         r.p2_y = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         r.point_z = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      end
      return r;
   endfunction

   // Hold until every outstanding item has come back.
   task automatic wait_drained();
      while (pending_nearest.size() != 0) @(posedge clock);
   endtask

   // Drive one register write; the caller drops the write enable afterwards.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [EPSW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic seg, logic [15:0] eps);
      wait_drained();
      write_csr(CSR_SEGMENT_MODE, EPSW'(seg));
      write_csr(CSR_EPSILON, eps);
      csr_wr_en <= 1'b0;
      seg_mode = seg;
      eps_val  = eps;
   endtask

   // Present one item, keeping start high if the next one follows directly.
   // The answer is queued at the edge that accepts the item.
   task automatic send_item(ptsn_req_type r, int idle_pct, bit typed,
                            ptsn_rsp_type given);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_nearest.push_back(typed ? given : predict_nearest(r, seg_mode, eps_val));
      items_sent++;
   endtask

   // Results come as one-cycle strobes; take each one at its edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_nearest.size() == 0) begin
            $display("%0t: result with nothing outstanding: %p", $time, rsp_data);
            fail_count++;
         end else begin
            ptsn_rsp_type want;
            want = pending_nearest.pop_front();
            if (rsp_data.near_x !== want.near_x || rsp_data.near_y !== want.near_y ||
                rsp_data.near_z !== want.near_z || rsp_data.distance !== want.distance ||
                rsp_data.where_found !== want.where_found ||
                rsp_data.saturated !== want.saturated) begin
               $display("%0t: mismatch expected %p", $time, want);
               $display("%0t:          actual   %p", $time, rsp_data);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: drop the run if neither side moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("watchdog expired at %0t", $time);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      vector_type   table_rows[$];
      vector_type   v;
      ptsn_rsp_type none;
      int           idle_pct;
      logic         seg;
      logic [15:0]  eps;

      none = '0;
      // after reset: segment mode, epsilon 1
      table_rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, 1,
                             make_answer(0, 0, 0, 0, WHERE_DEGEN)});
      table_rows.push_back('{make_query(ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0), 1, 1, 1,
                             make_answer(ONE, 0, 0, 0, WHERE_INTERIOR)});
      table_rows.push_back('{make_query(3 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0), 1, 1, 1,
                             make_answer(2 * ONE, 0, 0, ONE, WHERE_P2)});
      table_rows.push_back('{make_query(-ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0), 1, 1, 1,
                             make_answer(0, 0, 0, ONE, WHERE_P1)});
      table_rows.push_back('{make_query(ONE, ONE, 0, 0, 0, 0, 2 * ONE, 0, 0), 1, 1, 1,
                             make_answer(ONE, 0, 0, ONE, WHERE_INTERIOR)});
      // t exactly 1 and exactly 0
      table_rows.push_back('{make_query(2 * ONE, 5 * ONE, 0, 0, 0, 0, 2 * ONE, 0, 0),
                             1, 1, 1, make_answer(2 * ONE, 0, 0, 5 * ONE, WHERE_P2)});
      table_rows.push_back('{make_query(0, 3 * ONE, 0, 0, 0, 0, 2 * ONE, 0, 0), 1, 1, 1,
                             make_answer(0, 0, 0, 3 * ONE, WHERE_P1)});
      // endpoints within epsilon, and just outside it
      table_rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 1, -1, 1), 1, 1, 1,
                             make_answer(0, 0, 0, 0, WHERE_DEGEN)});
      table_rows.push_back('{make_query(ONE, ONE, 0, 0, 0, 0, 2, 0, 0), 1, 1, 0, none});
      // coordinate extremes
      table_rows.push_back('{make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff), 1, 1, 0, none});
      table_rows.push_back('{make_query(32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff), 1, 1, 0, none});
      table_rows.push_back('{make_query(32'h80000000, 32'h7fffffff, 32'h80000000,
                             32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                             32'h7fffffff, 32'h80000000), 1, 1, 0, none});
      // infinite line: no clamping, and projections past the coordinate range
      table_rows.push_back('{make_query(3 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0), 0, 1, 1,
                             make_answer(3 * ONE, 0, 0, 0, WHERE_INTERIOR)});
      table_rows.push_back('{make_query(32'h7fffffff, 32'h7fffffff, 0, 32'h7fffff00, 0, 0,
                             32'h7fffff80, 32'h100, 0), 0, 1, 0, none});
      table_rows.push_back('{make_query(32'h80000000, 32'h80000000, 0, 32'h80000100, 0,
                             0, 32'h80000080, -32'sh100, 0), 0, 1, 0, none});
      table_rows.push_back('{make_query(32'h80000000, 32'h7fffffff, 32'h80000000,
                             32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                             32'h7fffffff, 32'h80000000), 0, 1, 0, none});
      // epsilon extremes
      table_rows.push_back('{make_query(ONE, 0, 0, 0, 0, 0, 1, 0, 0), 0, 0, 0, none});
      table_rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 1,
                             make_answer(0, 0, 0, 0, WHERE_DEGEN)});
      table_rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 32'hffff, -32'shffff, 0), 1,
                             16'hffff, 1, make_answer(0, 0, 0, 0, WHERE_DEGEN)});
      table_rows.push_back('{make_query(ONE, ONE, ONE, 0, 0, 0, 32'h10000, 0, 0), 1,
                             16'hffff, 0, none});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; rewrite the registers only when a row asks for it
      foreach (table_rows[i]) begin
         v = table_rows[i];
         if (v.seg !== seg_mode || v.eps !== eps_val) begin
            start <= 1'b0;
            apply_setting(v.seg, v.eps);
         end
         send_item(v.req, 0, v.typed, v.rsp);
      end
      start <= 1'b0;

      // random phases; cycle through the idle patterns and register settings
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin seg = 1'b1; eps = 16'd1;     end
            1: begin seg = 1'b0; eps = 16'd0;     end
            2: begin seg = 1'b1; eps = 16'hffff;  end
            3: begin seg = 1'b0; eps = 16'hffff;  end
            default: begin
               seg = $urandom_range(0, 1);
               eps = $urandom_range(0, 16'hffff);
            end
         endcase
         case (ph % 4)
            1:       idle_pct = 85;
            3:       idle_pct = 34;
            default: idle_pct = 0;
         endcase
         apply_setting(seg, eps);
         for (int n = 0; n < PHASE_LEN; n++) begin
            send_item(random_query(eps_val), idle_pct, 1'b0, none);
         end
         start <= 1'b0;
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d items and %0d results over %0d register settings",
               items_sent, results_seen, PHASES + 4);
      $display("segment and line modes, epsilon 0 through 65535, idle rates 0/34/85");
      if (fail_count == 0 && pending_nearest.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d failures, %0d results missing", fail_count, pending_nearest.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
